[design/ctd_pkg.sv]
// ----------------------------------------------------------------------------
// ctd_pkg: shared types and constants for the chunked transfer decoder
// Parser phases, status codes, framing characters and the hex digit decode.
// ----------------------------------------------------------------------------
package ctd_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_CR = 3'd1,
    PH_EXT     = 3'd2,
    PH_EXT_CR  = 3'd3,
    PH_DATA    = 3'd4,
    PH_DATA_CR = 3'd5,
    PH_DATA_LF = 3'd6,
    PH_END     = 3'd7
  } phase_t;

  // Status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_INC  = 2'd3;

  // Framing characters
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SEMI = 8'h3b;

  // Bits per hex digit
  localparam int unsigned DIGIT_BITS = 4;

  // Parser control state handed between the step logic and the top level
  typedef struct packed {
    phase_t     phase;
    logic [1:0] fstat;
  } ctl_t;

  // Hex digit decode result
  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  // Decode one character as a hex digit, either case
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

[design/ctd_step.sv]
// ----------------------------------------------------------------------------
// ctd_step: next-state and result logic for one body byte
// Advances the size line / payload / CRLF parser by one byte and forms the
// result item for that byte.
// ----------------------------------------------------------------------------
module ctd_step #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  ctd_pkg::ctl_t          ctl_cur,
  input  logic [SIZE_BITS-1:0]   count_cur,
  input  logic [7:0]             body_byte,
  input  logic                   first_byte,
  input  logic                   end_of_body,
  output ctd_pkg::ctl_t          ctl_nxt,
  output logic [SIZE_BITS-1:0]   count_nxt,
  output logic                   data_valid,
  output logic [7:0]             out_byte,
  output logic [1:0]             status
);

  ctd_pkg::ctl_t        ctl_in;
  logic [SIZE_BITS-1:0] count_in;
  logic [SIZE_BITS-1:0] count_dec;
  ctd_pkg::hex_t        hex;
  logic                 size_top_set;

  // Restart the parser on the first byte of a body
  always_comb begin
    if (first_byte) begin
      ctl_in.phase = ctd_pkg::PH_SIZE;
      ctl_in.fstat = ctd_pkg::ST_RUN;
      count_in     = '0;
    end else begin
      ctl_in   = ctl_cur;
      count_in = count_cur;
    end
  end

  assign hex          = ctd_pkg::hex_decode(body_byte);
  assign size_top_set = |count_in[SIZE_BITS-1 -: ctd_pkg::DIGIT_BITS];
  assign count_dec    = count_in - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  // Advance the phase and the size / remaining count
  always_comb begin
    ctl_nxt    = ctl_in;
    count_nxt  = count_in;
    data_valid = 1'b0;
    out_byte   = 8'd0;
    unique case (ctl_in.phase) inside
      ctd_pkg::PH_SIZE: begin
        if (hex.is_hex) begin
          if (size_top_set) begin
            ctl_nxt.phase = ctd_pkg::PH_END;
            ctl_nxt.fstat = ctd_pkg::ST_BAD;
          end else begin
            count_nxt = {count_in[SIZE_BITS-ctd_pkg::DIGIT_BITS-1:0], hex.value};
          end
        end else if (body_byte == ctd_pkg::CH_SEMI) begin
          ctl_nxt.phase = ctd_pkg::PH_EXT;
        end else if (body_byte == ctd_pkg::CH_CR) begin
          ctl_nxt.phase = ctd_pkg::PH_SIZE_CR;
        end else begin
          ctl_nxt.phase = ctd_pkg::PH_END;
          ctl_nxt.fstat = ctd_pkg::ST_BAD;
        end
      end
      ctd_pkg::PH_SIZE_CR, ctd_pkg::PH_EXT_CR: begin
        if (body_byte == ctd_pkg::CH_LF) begin
          // end of size line: zero size ends the body
          if (count_in == '0) begin
            ctl_nxt.phase = ctd_pkg::PH_END;
            ctl_nxt.fstat = ctd_pkg::ST_DONE;
          end else begin
            ctl_nxt.phase = ctd_pkg::PH_DATA;
          end
        end else if (ctl_in.phase == ctd_pkg::PH_SIZE_CR) begin
          ctl_nxt.phase = ctd_pkg::PH_END;
          ctl_nxt.fstat = ctd_pkg::ST_BAD;
        end else if (body_byte != ctd_pkg::CH_CR) begin
          ctl_nxt.phase = ctd_pkg::PH_EXT;
        end
      end
      ctd_pkg::PH_EXT: begin
        if (body_byte == ctd_pkg::CH_CR) begin
          ctl_nxt.phase = ctd_pkg::PH_EXT_CR;
        end
      end
      ctd_pkg::PH_DATA: begin
        data_valid = 1'b1;
        out_byte   = body_byte;
        count_nxt  = count_dec;
        if (count_dec == '0) begin
          ctl_nxt.phase = ctd_pkg::PH_DATA_CR;
        end
      end
      ctd_pkg::PH_DATA_CR: begin
        if (body_byte == ctd_pkg::CH_CR) begin
          ctl_nxt.phase = ctd_pkg::PH_DATA_LF;
        end else begin
          ctl_nxt.phase = ctd_pkg::PH_END;
          ctl_nxt.fstat = ctd_pkg::ST_BAD;
        end
      end
      ctd_pkg::PH_DATA_LF: begin
        if (body_byte == ctd_pkg::CH_LF) begin
          ctl_nxt.phase = ctd_pkg::PH_SIZE;
          count_nxt     = '0;
        end else begin
          ctl_nxt.phase = ctd_pkg::PH_END;
          ctl_nxt.fstat = ctd_pkg::ST_BAD;
        end
      end
      default: begin
      end
    endcase
  end

  // Report incomplete when input runs out on a live body
  assign status = (ctl_nxt.fstat == ctd_pkg::ST_RUN && end_of_body) ?
                  ctd_pkg::ST_INC : ctl_nxt.fstat;

endmodule

[design/chunked_transfer_decoder.sv]
// ----------------------------------------------------------------------------
// Each accepted body byte gives a registered result item in the next cycle.
// Throughput: one byte per cycle; the parser state updates in the accept cycle.
// A new byte is taken while the previous result waits, as long as the result
// register is free or being drained in the same cycle.
// Reset: parser returns to the size line with count zero, status running,
// and the result register empties.
// ----------------------------------------------------------------------------
// chunked_transfer_decoder: HTTP chunked body decoder
// Parses size lines, extensions and CRLF framing one byte at a time and
// passes the payload bytes out with a running status.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_body_byte,
  input  logic       in_first_byte,
  input  logic       in_end_of_body,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_data_valid,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_status
);

  ctd_pkg::ctl_t        ctl_r;
  ctd_pkg::ctl_t        ctl_nxt;
  logic [SIZE_BITS-1:0] count_r;
  logic [SIZE_BITS-1:0] count_nxt;
  logic                 out_valid_r;
  logic                 data_valid_r;
  logic                 data_valid_nxt;
  logic [7:0]           out_byte_r;
  logic [7:0]           out_byte_nxt;
  logic [1:0]           status_r;
  logic [1:0]           status_nxt;
  logic                 in_acc;

  // Take an item when the result register is empty or draining
  assign in_ready = ~out_valid_r | out_ready;
  assign in_acc   = in_valid & in_ready;

  ctd_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .ctl_cur     (ctl_r),
    .count_cur   (count_r),
    .body_byte   (in_body_byte),
    .first_byte  (in_first_byte),
    .end_of_body (in_end_of_body),
    .ctl_nxt     (ctl_nxt),
    .count_nxt   (count_nxt),
    .data_valid  (data_valid_nxt),
    .out_byte    (out_byte_nxt),
    .status      (status_nxt)
  );

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase <= ctd_pkg::PH_SIZE;
      ctl_r.fstat <= ctd_pkg::ST_RUN;
      count_r     <= '0;
    end else if (in_acc) begin
      ctl_r   <= ctl_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the result item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_valid_r <= data_valid_nxt;
      out_byte_r   <= out_byte_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_valid = data_valid_r;
  assign out_out_byte   = out_byte_r;
  assign out_status     = status_r;

endmodule
